/* rtl/dxt1_pkg.sv */
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types, constants and helper functions for the BC1 block decoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

    // Widths of the stream payloads
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 40;
    localparam int TEXELS      = 16;
    localparam int TEXEL_NUM_W = 4;

    // Default depth of the block queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Palette entry codes
    localparam logic [1:0] IDX_COLOR0 = 2'd0;
    localparam logic [1:0] IDX_COLOR1 = 2'd1;
    localparam logic [1:0] IDX_MIX_A  = 2'd2;
    localparam logic [1:0] IDX_MIX_B  = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    // One RGBA8 colour
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // One decoded block: four-entry palette plus the texel indices
    typedef struct packed {
        t_rgba [3:0] palette;
        logic [31:0] index_bits;
    } t_block;

    // Expansion tables for 5-bit and 6-bit channels, truncating c*255/max
    typedef logic [7:0] t_tab5 [32];
    typedef logic [7:0] t_tab6 [64];

    function automatic t_tab5 f_build_tab5();
        t_tab5 t;
        for (int i = 0; i < 32; i++) begin
            t[i] = 8'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic t_tab6 f_build_tab6();
        t_tab6 t;
        for (int i = 0; i < 64; i++) begin
            t[i] = 8'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam t_tab5 EXPAND5 = f_build_tab5();
    localparam t_tab6 EXPAND6 = f_build_tab6();

    // Truncating divide by three for sums up to 765: x*683 >> 11
    function automatic logic [7:0] f_div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

endpackage

/* rtl/dxt1_front.sv */
// ----------------------------------------------------------------------------
// dxt1_front
// Accepts a BC1 block, expands the endpoints and builds the 4-entry palette.
// ----------------------------------------------------------------------------
module dxt1_front (
    input  logic [15:0]     i_color_zero,
    input  logic [15:0]     i_color_one,
    input  logic [31:0]     i_index_bits,
    output dxt1_pkg::t_block o_block
);
    import dxt1_pkg::*;

    logic [7:0] a_ch [3];
    logic [7:0] b_ch [3];
    logic       four_colour;

    // Endpoint expansion through constant tables
    always_comb begin
        a_ch[0] = EXPAND5[i_color_zero[15:11]];
        a_ch[1] = EXPAND6[i_color_zero[10:5]];
        a_ch[2] = EXPAND5[i_color_zero[4:0]];
        b_ch[0] = EXPAND5[i_color_one[15:11]];
        b_ch[1] = EXPAND6[i_color_one[10:5]];
        b_ch[2] = EXPAND5[i_color_one[4:0]];
    end

    assign four_colour = (i_color_zero > i_color_one);

    // Palette: endpoints, then thirds or half plus transparent black
    always_comb begin
        logic [9:0] two_a_b;
        logic [9:0] a_two_b;
        logic [8:0] a_b;
        logic [7:0] mix_a [3];
        logic [7:0] mix_b [3];
        for (int k = 0; k < 3; k++) begin
            two_a_b = {1'b0, a_ch[k], 1'b0} + 10'(b_ch[k]);
            a_two_b = 10'(a_ch[k]) + {1'b0, b_ch[k], 1'b0};
            a_b     = 9'(a_ch[k]) + 9'(b_ch[k]);
            if (four_colour) begin
                mix_a[k] = f_div3(two_a_b);
                mix_b[k] = f_div3(a_two_b);
            end else begin
                mix_a[k] = a_b[8:1];
                mix_b[k] = 8'd0;
            end
        end
        o_block.palette[IDX_COLOR0] = '{a_ch[0], a_ch[1], a_ch[2], ALPHA_OPAQUE};
        o_block.palette[IDX_COLOR1] = '{b_ch[0], b_ch[1], b_ch[2], ALPHA_OPAQUE};
        o_block.palette[IDX_MIX_A]  = '{mix_a[0], mix_a[1], mix_a[2], ALPHA_OPAQUE};
        o_block.palette[IDX_MIX_B]  = '{mix_b[0], mix_b[1], mix_b[2],
                                        four_colour ? ALPHA_OPAQUE : ALPHA_CLEAR};
        o_block.index_bits = i_index_bits;
    end

endmodule

/* rtl/dxt1_queue.sv */
// ----------------------------------------------------------------------------
// dxt1_queue
// Short register queue of decoded palettes between front and back.
// ----------------------------------------------------------------------------
module dxt1_queue #(
    parameter int DEPTH = dxt1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dxt1_pkg::t_block i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output dxt1_pkg::t_block o_data
);
    import dxt1_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_block             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and fill count update, wrapping at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* rtl/dxt1_back.sv */
// ----------------------------------------------------------------------------
// dxt1_back
// Walks the sixteen texels of the queue head and drives the output register.
// ----------------------------------------------------------------------------
module dxt1_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_empty,
    input  dxt1_pkg::t_block                  i_block,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output dxt1_pkg::t_rgba                   o_texel,
    output logic [dxt1_pkg::TEXEL_NUM_W-1:0]  o_texel_number,
    output logic                              o_last
);
    import dxt1_pkg::*;

    logic [TEXEL_NUM_W-1:0] r_cnt;
    logic                   r_valid;
    t_rgba                  r_texel;
    logic [TEXEL_NUM_W-1:0] r_num;
    logic                   r_last;
    logic                   emit;
    logic                   last_of_block;
    logic [1:0]             sel;

    // A texel moves out whenever a block waits and the output slot is free
    assign emit          = !i_empty && (!r_valid || i_ready);
    assign last_of_block = (r_cnt == TEXEL_NUM_W'(TEXELS - 1));
    assign sel           = i_block.index_bits[{r_cnt, 1'b0} +: 2];
    assign o_pop         = emit && last_of_block;

    // Control: texel counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_texel <= i_block.palette[sel];
            r_num   <= r_cnt;
            r_last  <= last_of_block;
        end
    end

    assign o_valid        = r_valid;
    assign o_texel        = r_texel;
    assign o_texel_number = r_num;
    assign o_last         = r_last;

endmodule

/* rtl/dxt1_block_decoder_top.sv */
// ----------------------------------------------------------------------------
// dxt1_block_decoder_top
// BC1 (DXT1) block decoder: one 8-byte block in, sixteen RGBA8 texels out.
// ----------------------------------------------------------------------------
// Each accepted block yields sixteen output beats, texel 0 to 15 in row-major
// order, with tlast on texel 15. The output carries one texel per cycle while
// m_axis_tready is high, so the sustained block rate is set by the output channel.
// The palette is built in the cycle a block is accepted and held in a queue
// of QUEUE_DEPTH blocks; its texels go from the queue storage through the output register.
// A block is accepted whenever the queue has room, also while earlier texels
// are still going out or stalled. The block keeps no state between blocks.
// ----------------------------------------------------------------------------
module dxt1_block_decoder_top #(
    parameter int QUEUE_DEPTH = dxt1_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [15:0] color_zero, [31:16] color_one, [63:32] index_bits
    input  logic [dxt1_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [35:32] texel_number, [39:36] zero
    output logic [dxt1_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);
    import dxt1_pkg::*;

    t_block                 front_block;
    t_block                 head_block;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic                   push;
    t_rgba                  texel;
    logic [TEXEL_NUM_W-1:0] texel_number;

    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && !q_full;

    dxt1_front u_front (
        .i_color_zero (s_axis_tdata[15:0]),
        .i_color_one  (s_axis_tdata[31:16]),
        .i_index_bits (s_axis_tdata[63:32]),
        .o_block      (front_block)
    );

    dxt1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_block),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_block)
    );

    dxt1_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_block        (head_block),
        .o_pop          (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_texel        (texel),
        .o_texel_number (texel_number),
        .o_last         (m_axis_tlast)
    );

    // Output beat packing
    assign m_axis_tdata = {4'd0, texel_number, texel.alpha, texel.blue,
                           texel.green, texel.red};

endmodule

/* tb/dxt1_block_decoder_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dxt1_block_decoder_top_test
// Self-checking bench for the BC1 block decoder. Blocks go in on the slave
// stream. Each accepted block is expanded here into its sixteen expected
// texels. Every texel beat that leaves the master stream is compared, field
// by field, with the oldest expected texel. Both streams idle at random.
// ----------------------------------------------------------------------------
module dxt1_block_decoder_top_test;
    import dxt1_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_BLOCKS = 420;
    localparam int IDLE_PERCENT  = 25;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int REPORT_LIMIT  = 10;

    // One expected texel
    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [3:0] number;
        logic       last;
    } t_texel;

    // Expands blocks into texels and checks the texel stream against them
    class texel_scoreboard;
        t_texel expected_texels[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_texels.size();
        endfunction

        // Build the four-entry palette, then look up each texel index
        function void note_block(input logic [15:0] c0, input logic [15:0] c1,
                                 input logic [31:0] idx);
            int unsigned ends[2][3];
            int unsigned a;
            int unsigned b;
            logic [7:0]  pal[4][4];
            logic [15:0] c;
            logic [1:0]  sel;
            t_texel      t;

            for (int e = 0; e < 2; e++) begin
                c = (e == 0) ? c0 : c1;
                ends[e][0] = (int'(c[15:11]) * 255) / 31;
                ends[e][1] = (int'(c[10:5]) * 255) / 63;
                ends[e][2] = (int'(c[4:0]) * 255) / 31;
            end
            for (int k = 0; k < 3; k++) begin
                a = ends[0][k];
                b = ends[1][k];
                pal[IDX_COLOR0][k] = 8'(a);
                pal[IDX_COLOR1][k] = 8'(b);
                // four-colour mode only when colour 0 is strictly greater
                if (c0 > c1) begin
                    pal[IDX_MIX_A][k] = 8'((2 * a + b) / 3);
                    pal[IDX_MIX_B][k] = 8'((a + 2 * b) / 3);
                end else begin
                    pal[IDX_MIX_A][k] = 8'((a + b) / 2);
                    pal[IDX_MIX_B][k] = 8'h00;
                end
            end
            pal[IDX_COLOR0][3] = ALPHA_OPAQUE;
            pal[IDX_COLOR1][3] = ALPHA_OPAQUE;
            pal[IDX_MIX_A][3]  = ALPHA_OPAQUE;
            pal[IDX_MIX_B][3]  = (c0 > c1) ? ALPHA_OPAQUE : ALPHA_CLEAR;

            for (int n = 0; n < 16; n++) begin
                sel      = idx[2*n +: 2];
                t.red    = pal[sel][0];
                t.green  = pal[sel][1];
                t.blue   = pal[sel][2];
                t.alpha  = pal[sel][3];
                t.number = 4'(n);
                t.last   = (n == 15);
                expected_texels.push_back(t);
            end
        endfunction

        // Compare one texel beat with the oldest expectation
        function void check_texel(input logic [39:0] data, input logic last);
            t_texel want;
            logic   same;

            if (expected_texels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("texel beat with no block pending: data=%h last=%b",
                             data, last);
                return;
            end
            want = expected_texels.pop_front();
            same = (data[7:0] === want.red) && (data[15:8] === want.green) &&
                   (data[23:16] === want.blue) && (data[31:24] === want.alpha) &&
                   (data[35:32] === want.number) && (last === want.last);
            if (!same) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("texel mismatch: expected r=%h g=%h b=%h a=%h n=%0d last=%b, %s",
                             want.red, want.green, want.blue, want.alpha, want.number,
                             want.last,
                             $sformatf("got r=%h g=%h b=%h a=%h n=%0d last=%b",
                                       data[7:0], data[15:8], data[23:16],
                                       data[31:24], data[35:32], last));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [15:0] color_zero, [31:16] color_one, [63:32] index_bits
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    // [35:32] texel_number, [39:36] zero
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic            no_idle;
    int              cycle_count = 0;
    texel_scoreboard sb;

    dxt1_block_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dxt1_block_decoder_top verification failed");
            $finish;
        end
    end

    // Texel sink: check each beat, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_texel(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Present one block and hold it until accepted
    task automatic send_block(input logic [15:0] c0, input logic [15:0] c1,
                              input logic [31:0] idx);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {idx, c1, c0};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_block(c0, c1, idx);
    endtask

    // Drop valid and hold off until every texel has come back
    task automatic drain_texels();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'hF800;
            3:       return 16'h07E0;
            4:       return 16'h001F;
            default: return 16'h0821;
        endcase
    endfunction

    // Random block, biased towards equal, adjacent and extreme endpoints
    task automatic random_block();
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] idx;
        int          mode;

        mode = $urandom_range(99);
        c0   = 16'($urandom);
        c1   = 16'($urandom);
        idx  = $urandom;
        if (mode < 20) begin
            c1 = c0;
        end else if (mode < 30) begin
            c1 = $urandom_range(1) ? c0 + 16'd1 : c0 - 16'd1;
        end else if (mode < 40) begin
            c0 = pick_extreme();
            c1 = pick_extreme();
        end
        if ($urandom_range(9) == 0)
            idx = {16{2'($urandom_range(3))}};
        send_block(c0, c1, idx);
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        no_idle       = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed blocks: extremes, both modes, every index
        send_block(16'h0000, 16'h0000, 32'h0000_0000);
        send_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_block(16'hFFFF, 16'h0000, 32'h0000_0000);
        send_block(16'hFFFF, 16'h0000, 32'h5555_5555);
        send_block(16'hFFFF, 16'h0000, 32'hAAAA_AAAA);
        send_block(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        send_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4);
        send_block(16'h0000, 16'hFFFF, 32'hE4E4_E4E4);
        send_block(16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        send_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B);
        // equal endpoints fall into three-colour mode
        send_block(16'h1234, 16'h1234, 32'hFFFF_FFFF);
        send_block(16'h8000, 16'h8000, 32'h4E4E_4E4E);
        // one apart either way
        send_block(16'h8001, 16'h8000, 32'hE4E4_E4E4);
        send_block(16'h8000, 16'h8001, 32'hE4E4_E4E4);
        send_block(16'hF800, 16'h001F, 32'hD8D8_D8D8);
        send_block(16'h07E0, 16'hF81F, 32'h2727_2727);
        send_block(16'h001F, 16'h07E0, 32'h9C9C_9C9C);
        send_block(16'hFFFE, 16'h0001, 32'h0123_4567);
        send_block(16'h0841, 16'h0020, 32'h89AB_CDEF);
        send_block(16'h7BEF, 16'h8410, 32'hFEDC_BA98);
        drain_texels();

        for (int i = 0; i < RANDOM_BLOCKS; i++) begin
            if (i == 150)
                no_idle <= 1'b1;
            if (i == 260)
                no_idle <= 1'b0;
            if (i == 320)
                drain_texels();
            random_block();
        end
        drain_texels();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("dxt1_block_decoder_top verification clean");
        else
            $display("dxt1_block_decoder_top verification failed");
        $finish;
    end

endmodule
